// File: rtl/lzos_pkg.sv
// Package for the layer z-order stack: field widths, request codes,
// controller states. No dependencies.
package lzos_pkg;

  localparam int unsigned MaxLayers  = 256;
  localparam int unsigned LayerIdW   = 8;
  localparam int unsigned HeightW    = 9;
  localparam int unsigned ReqHeightW = 10;
  localparam int unsigned CountW     = 9;

  localparam logic signed [HeightW-1:0] HeightHidden = '1;  // -1

  typedef enum logic [1:0] {
    REQ_ALLOC      = 2'd0,
    REQ_SET_HEIGHT = 2'd1,
    REQ_FREE       = 2'd2,
    REQ_READ_SLOT  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_HEIGHT_RD,
    ST_SHIFT,
    ST_FINISH,
    ST_SLOT_RD,
    ST_RESP
  } state_e;

endpackage

// File: rtl/lzos_req_if.sv
// Request channel of the layer z-order stack: valid/ready plus request fields.
// Depends on lzos_pkg.
interface lzos_req_if;
  import lzos_pkg::*;

  logic                          valid;
  logic                          ready;
  req_type_e                     req_type;
  logic [LayerIdW-1:0]           layer_id;
  logic signed [ReqHeightW-1:0]  req_height;

  modport source (output valid, req_type, layer_id, req_height, input ready);
  modport sink   (input valid, req_type, layer_id, req_height, output ready);
endinterface

// File: rtl/lzos_rsp_if.sv
// Response channel of the layer z-order stack: valid/ready plus result fields.
// Depends on lzos_pkg.
interface lzos_rsp_if;
  import lzos_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [LayerIdW-1:0]        result_layer;
  logic signed [HeightW-1:0]  new_height;
  logic [CountW-1:0]          visible_count;

  modport source (output valid, ok, result_layer, new_height, visible_count, input ready);
  modport sink   (input valid, ok, result_layer, new_height, visible_count, output ready);
endinterface

// File: rtl/layer_z_order_stack.sv
// Layer z-order stack: one request at a time. Read slot reads the order table once; an ignored
//   request or a slot out of range goes straight to the result; allocate checks one in-use bit
//   per cycle; set height / free reads the old height, moves N order-table entries one per
//   cycle (N up to 255, possibly none), then writes the new height.
// The next request beat is taken once the result sits in the output register.
// Reset (async, active low) clears in-use bits and sets top to -1; memories are not cleared.
module layer_z_order_stack (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzos_req_if.sink    req_i,
  lzos_rsp_if.source  rsp_o
);
  import lzos_pkg::*;

  // ---------------------------------------------------------------------------
  // Control and request registers
  // ---------------------------------------------------------------------------
  state_e                       state_q, state_d;
  req_type_e                    type_q, type_d;
  logic [LayerIdW-1:0]          id_q, id_d;
  logic signed [ReqHeightW-1:0] req_q, req_d;
  logic signed [ReqHeightW-1:0] h_q, h_d;       // clamped target height
  logic signed [HeightW-1:0]    top_q, top_d;   // height of the top visible layer
  logic [MaxLayers-1:0]         in_use_q, in_use_d;
  logic [LayerIdW-1:0]          scan_q, scan_d;

  // shift engine: src is the next entry read, dst the slot the pending data lands in
  logic                         dir_up_q, dir_up_d;
  logic [LayerIdW-1:0]          src_q, src_d;
  logic [LayerIdW-1:0]          dst_q, dst_d;
  logic [CountW-1:0]            cnt_q, cnt_d;
  logic                         rd_pend_q, rd_pend_d;

  // result being built
  logic                         res_ok_q, res_ok_d;
  logic [LayerIdW-1:0]          res_layer_q, res_layer_d;
  logic signed [HeightW-1:0]    res_nh_q, res_nh_d;

  // output register
  logic                         rsp_valid_q, rsp_valid_d;
  logic                         out_ok_q;
  logic [LayerIdW-1:0]          out_layer_q;
  logic signed [HeightW-1:0]    out_nh_q;
  logic [CountW-1:0]            out_vis_q;
  logic                         load_out;
  logic [CountW-1:0]            vis_w;

  // ---------------------------------------------------------------------------
  // Memories: order table (slot -> layer) and layer heights (layer -> slot)
  // ---------------------------------------------------------------------------
  logic [LayerIdW-1:0]          ot_mem_q [MaxLayers];
  logic signed [HeightW-1:0]    lh_mem_q [MaxLayers];
  logic [LayerIdW-1:0]          ot_rdata_q;
  logic signed [HeightW-1:0]    lh_rdata_q;

  logic                         ot_re, ot_we;
  logic [LayerIdW-1:0]          ot_raddr, ot_waddr, ot_wdata;
  logic                         lh_re, lh_we;
  logic [LayerIdW-1:0]          lh_raddr, lh_waddr;
  logic signed [HeightW-1:0]    lh_wdata;

  always_ff @(posedge clk_i) begin
    if (ot_we) begin
      ot_mem_q[ot_waddr] <= ot_wdata;
    end
    if (ot_re) begin
      ot_rdata_q <= ot_mem_q[ot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lh_we) begin
      lh_mem_q[lh_waddr] <= lh_wdata;
    end
    if (lh_re) begin
      lh_rdata_q <= lh_mem_q[lh_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Height-change plan, evaluated when the old height comes out of memory.
  // Four moves:
  //   lower a visible layer   : entries h..old-1 move up one slot
  //   hide a visible layer    : entries old+1..top move down, top shrinks
  //   raise a visible layer   : entries old+1..h move down one slot
  //   show a hidden layer     : entries h..top move up, top grows
  // ---------------------------------------------------------------------------
  logic signed [10:0] old_w, top_w, req_w, lim_w, hc_w;
  logic signed [10:0] plan_src_w, plan_cnt_w, plan_top_w;
  logic               plan_up;

  always_comb begin
    old_w = {{2{lh_rdata_q[HeightW-1]}}, lh_rdata_q};
    top_w = {{2{top_q[HeightW-1]}}, top_q};
    req_w = {req_q[ReqHeightW-1], req_q};
    // a visible layer cannot go past the top, a hidden one may land just above it
    lim_w = old_w[10] ? top_w + 11'sd1 : top_w;
    hc_w  = (req_w > lim_w) ? lim_w : req_w;
    if (hc_w < -11'sd1) begin
      hc_w = -11'sd1;
    end

    plan_up    = 1'b0;
    plan_src_w = '0;
    plan_cnt_w = '0;
    plan_top_w = top_w;
    if (old_w > hc_w) begin
      if (!hc_w[10]) begin
        plan_up    = 1'b1;
        plan_src_w = old_w - 11'sd1;
        plan_cnt_w = old_w - hc_w;
      end else begin
        plan_src_w = old_w + 11'sd1;
        plan_cnt_w = top_w - old_w;
        plan_top_w = top_w - 11'sd1;
      end
    end else if (old_w < hc_w) begin
      if (!old_w[10]) begin
        plan_src_w = old_w + 11'sd1;
        plan_cnt_w = hc_w - old_w;
      end else begin
        plan_up    = 1'b1;
        plan_src_w = top_w;
        plan_cnt_w = top_w - hc_w + 11'sd1;
        plan_top_w = top_w + 11'sd1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  assign vis_w = $unsigned(top_q) + 9'd1;

  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    id_d        = id_q;
    req_d       = req_q;
    h_d         = h_q;
    top_d       = top_q;
    in_use_d    = in_use_q;
    scan_d      = scan_q;
    dir_up_d    = dir_up_q;
    src_d       = src_q;
    dst_d       = dst_q;
    cnt_d       = cnt_q;
    rd_pend_d   = rd_pend_q;
    res_ok_d    = res_ok_q;
    res_layer_d = res_layer_q;
    res_nh_d    = res_nh_q;
    load_out    = 1'b0;
    req_i.ready = 1'b0;

    ot_re    = 1'b0;
    ot_raddr = '0;
    ot_we    = 1'b0;
    ot_waddr = '0;
    ot_wdata = '0;
    lh_re    = 1'b0;
    lh_raddr = '0;
    lh_we    = 1'b0;
    lh_waddr = '0;
    lh_wdata = '0;

    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          type_d      = req_i.req_type;
          id_d        = req_i.layer_id;
          // free is a hide to -1 followed by release
          req_d       = (req_i.req_type == REQ_FREE) ? -10'sd1 : req_i.req_height;
          res_ok_d    = 1'b0;
          res_layer_d = '0;
          res_nh_d    = HeightHidden;
          case (req_i.req_type)
            REQ_ALLOC: begin
              scan_d  = '0;
              state_d = ST_ALLOC_SCAN;
            end
            REQ_SET_HEIGHT, REQ_FREE: begin
              if (in_use_q[req_i.layer_id]) begin
                lh_re    = 1'b1;
                lh_raddr = req_i.layer_id;
                state_d  = ST_HEIGHT_RD;
              end else begin
                state_d = ST_RESP;
              end
            end
            REQ_READ_SLOT: begin
              if (!req_i.req_height[ReqHeightW-1] &&
                  (req_i.req_height <= $signed({top_q[HeightW-1], top_q}))) begin
                ot_re    = 1'b1;
                ot_raddr = req_i.req_height[LayerIdW-1:0];
                state_d  = ST_SLOT_RD;
              end else begin
                state_d = ST_RESP;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_ALLOC_SCAN: begin
        if (!in_use_q[scan_q]) begin
          in_use_d[scan_q] = 1'b1;
          lh_we       = 1'b1;
          lh_waddr    = scan_q;
          lh_wdata    = HeightHidden;
          res_ok_d    = 1'b1;
          res_layer_d = scan_q;
          state_d     = ST_RESP;
        end else if (scan_q == LayerIdW'(MaxLayers - 1)) begin
          state_d = ST_RESP;  // all slots taken
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      ST_HEIGHT_RD: begin
        h_d       = hc_w[ReqHeightW-1:0];
        dir_up_d  = plan_up;
        src_d     = plan_src_w[LayerIdW-1:0];
        cnt_d     = plan_cnt_w[CountW-1:0];
        top_d     = plan_top_w[HeightW-1:0];
        rd_pend_d = 1'b0;
        state_d   = ST_SHIFT;
      end

      ST_SHIFT: begin
        // write back the entry read last cycle and renumber its layer
        if (rd_pend_q) begin
          ot_we    = 1'b1;
          ot_waddr = dst_q;
          ot_wdata = ot_rdata_q;
          lh_we    = 1'b1;
          lh_waddr = ot_rdata_q;
          lh_wdata = {1'b0, dst_q};
        end
        if (cnt_q != '0) begin
          ot_re     = 1'b1;
          ot_raddr  = src_q;
          rd_pend_d = 1'b1;
          dst_d     = dir_up_q ? src_q + 1'b1 : src_q - 1'b1;
          src_d     = dir_up_q ? src_q - 1'b1 : src_q + 1'b1;
          cnt_d     = cnt_q - 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        lh_we    = 1'b1;
        lh_waddr = id_q;
        lh_wdata = h_q[HeightW-1:0];
        if (!h_q[ReqHeightW-1]) begin
          ot_we    = 1'b1;
          ot_waddr = h_q[LayerIdW-1:0];
          ot_wdata = id_q;
        end
        res_ok_d = 1'b1;
        if (type_q == REQ_FREE) begin
          in_use_d[id_q] = 1'b0;
        end else begin
          res_nh_d = h_q[HeightW-1:0];
        end
        state_d = ST_RESP;
      end

      ST_SLOT_RD: begin
        res_ok_d    = 1'b1;
        res_layer_d = ot_rdata_q;
        res_nh_d    = req_q[HeightW-1:0];
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_d = load_out | (rsp_valid_q & ~rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= HeightHidden;
      in_use_q    <= '0;
      rd_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      in_use_q    <= in_use_d;
      rd_pend_q   <= rd_pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_d_reg: begin
      type_q      <= type_d;
      id_q        <= id_d;
      req_q       <= req_d;
      h_q         <= h_d;
      scan_q      <= scan_d;
      dir_up_q    <= dir_up_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      cnt_q       <= cnt_d;
      res_ok_q    <= res_ok_d;
      res_layer_q <= res_layer_d;
      res_nh_q    <= res_nh_d;
    end
    if (load_out) begin
      out_ok_q    <= res_ok_q;
      out_layer_q <= res_layer_q;
      out_nh_q    <= res_nh_q;
      out_vis_q   <= vis_w;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.ok            = out_ok_q;
  assign rsp_o.result_layer  = out_layer_q;
  assign rsp_o.new_height    = out_nh_q;
  assign rsp_o.visible_count = out_vis_q;

`ifndef ASSERT_OFF
  // an accepted beat always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != ST_IDLE))
    else $error("request accepted but controller stayed idle");

  // the shift never reads the slot it is writing in the same cycle
  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && ot_re && ot_we) |-> (ot_raddr != ot_waddr))
    else $error("order table read and write collide during shift");

  // a freed layer is released once the request completes
  a_free_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && type_q == REQ_FREE) |=> !in_use_q[id_q])
    else $error("freed layer still marked in use");

  // never more visible layers than allocated ones
  a_visible_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(in_use_q) >= int'(vis_w)))
    else $error("visible count exceeds allocated layers");
`endif

endmodule
